// ===== src/qau_pkg.sv =====
// Shared types, codes and saturation helpers for the quaternion arithmetic unit.
package qau_pkg;

	localparam int QAU_FRAC_BITS = 16;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_SCALE = 4'd3,
		OP_CONJ  = 4'd4,
		OP_NORM  = 4'd5,
		OP_INV   = 4'd6,
		OP_NLERP = 4'd7,
		OP_MAT   = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] v;
		logic        f;
	} sat_t;

	// Item state carried down the pipeline. res holds the finished quaternion, row 0 of the
	// matrix, or the raw vector to normalize or invert; mrow holds matrix rows 1 and 2.
	typedef struct packed {
		logic [3:0]        mode;
		logic [3:0][31:0]  res;
		logic [5:0][31:0]  mrow;
		logic [2:0]        flag;
		logic [64:0]       sq;
	} carry_t;

	typedef struct packed {
		logic [3:0][32:0] q;
		logic [3:0]       ovf;
		logic             zero;
	} div_res_t;

	function automatic sat_t sat32(input logic signed [63:0] x);
		sat_t r;
		r.v = x[31:0];
		r.f = 1'b0;
		if (x > 64'sd2147483647) begin
			r.v = 32'h7fff_ffff;
			r.f = 1'b1;
		end else if (x < -64'sd2147483648) begin
			r.v = 32'h8000_0000;
			r.f = 1'b1;
		end
		return r;
	endfunction

	function automatic sat_t neg_sat(input logic [31:0] v);
		sat_t r;
		if (v == 32'h8000_0000) begin
			r.v = 32'h7fff_ffff;
			r.f = 1'b1;
		end else begin
			r.v = 32'd0 - v;
			r.f = 1'b0;
		end
		return r;
	endfunction

	// Apply sign to a quotient magnitude; ovf means the quotient reached 2^33.
	function automatic sat_t div_sat(input logic neg, input logic [32:0] q, input logic ovf);
		sat_t r;
		logic big;
		logic edge_val;
		big      = ovf || (q > 33'h0_8000_0000);
		edge_val = (q == 33'h0_8000_0000);
		if (neg) begin
			if (big || edge_val) begin
				r.v = 32'h8000_0000;
				r.f = big;
			end else begin
				r.v = 32'(33'd0 - q);
				r.f = 1'b0;
			end
		end else begin
			if (big || edge_val) begin
				r.v = 32'h7fff_ffff;
				r.f = 1'b1;
			end else begin
				r.v = q[31:0];
				r.f = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/qau_front.sv =====
// Front pipeline: operand routing, product lanes, per-op combine, sum of squares.
module qau_front import qau_pkg::*; #(
	parameter int FRAC_BITS = QAU_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [3:0]       mode,
	input  logic [3:0][31:0] a,
	input  logic [3:0][31:0] b,
	input  logic [31:0]      factor,
	output logic             out_valid,
	output carry_t           out_carry
);

	localparam logic signed [33:0] ONE_T  = 34'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] ONE_64 = 64'sd1 <<< FRAC_BITS;

	localparam logic [1:0] MUL_IA [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2};
	localparam logic [1:0] MUL_IB [16] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd3, 2'd2,
		2'd2, 2'd0, 2'd1, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1};
	// ss xx yy zz xy xz yz sx sy sz
	localparam logic [1:0] MAT_IA [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0,
		2'd0, 2'd0};
	localparam logic [1:0] MAT_IB [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1,
		2'd2, 2'd3};

	function automatic logic signed [63:0] sx64(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic signed [33:0] sx34(input logic [31:0] v);
		return {{2{v[31]}}, v};
	endfunction

	logic signed [31:0] lx [16];
	logic signed [33:0] ly [16];
	logic signed [33:0] omt;

	logic signed [31:0] lx_s1 [16];
	logic signed [33:0] ly_s1 [16];
	logic [3:0][31:0]   a_s1, b_s1;
	logic [3:0]         mode_s1;
	logic               v_s1;

	logic signed [65:0] prod [16];
	logic signed [63:0] p_s2 [16];
	logic [3:0][31:0]   a_s2, b_s2;
	logic [3:0]         mode_s2;
	logic               v_s2;

	carry_t             c_nxt;
	carry_t             c_s3;
	logic               v_s3;

	logic [3:0][31:0]   mag;
	logic [63:0]        sq_s4 [4];
	carry_t             c_s4;
	logic               v_s4;

	carry_t             c5_nxt;
	carry_t             c_s5;
	logic               v_s5;

	// Route operands into the sixteen product lanes.
	always_comb begin
		omt = ONE_T - sx34(factor);
		for (int k = 0; k < 16; k++) begin
			lx[k] = '0;
			ly[k] = '0;
		end
		case (mode)
			OP_MUL: begin
				for (int k = 0; k < 16; k++) begin
					lx[k] = a[MUL_IA[k]];
					ly[k] = sx34(b[MUL_IB[k]]);
				end
			end
			OP_SCALE: begin
				for (int k = 0; k < 4; k++) begin
					lx[k] = a[k];
					ly[k] = sx34(factor);
				end
			end
			OP_NLERP: begin
				for (int k = 0; k < 4; k++) begin
					lx[k]     = a[k];
					ly[k]     = omt;
					lx[k + 4] = b[k];
					ly[k + 4] = sx34(factor);
				end
			end
			OP_MAT: begin
				for (int k = 0; k < 10; k++) begin
					lx[k] = a[MAT_IA[k]];
					ly[k] = sx34(a[MAT_IB[k]]);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 16; k++)
			prod[k] = lx_s1[k] * ly_s1[k];
	end

	// Combine floored products per op, saturate to 32 bits.
	always_comb begin
		sat_t sv [4];
		sat_t em [9];
		logic signed [63:0] p [16];
		for (int k = 0; k < 16; k++)
			p[k] = p_s2[k];
		c_nxt      = '0;
		c_nxt.mode = mode_s2;
		for (int i = 0; i < 4; i++)
			sv[i] = '0;
		for (int i = 0; i < 9; i++)
			em[i] = '0;
		case (mode_s2)
			OP_ADD: begin
				for (int i = 0; i < 4; i++)
					sv[i] = sat32(sx64(a_s2[i]) + sx64(b_s2[i]));
			end
			OP_SUB: begin
				for (int i = 0; i < 4; i++)
					sv[i] = sat32(sx64(a_s2[i]) - sx64(b_s2[i]));
			end
			OP_MUL: begin
				sv[0] = sat32(p[0] - p[1] - p[2] - p[3]);
				sv[1] = sat32(p[4] + p[5] + p[6] - p[7]);
				sv[2] = sat32(p[8] + p[9] + p[10] - p[11]);
				sv[3] = sat32(p[12] + p[13] + p[14] - p[15]);
			end
			OP_SCALE: begin
				for (int i = 0; i < 4; i++)
					sv[i] = sat32(p[i]);
			end
			OP_CONJ: begin
				sv[0].v = a_s2[0];
				for (int i = 1; i < 4; i++)
					sv[i] = neg_sat(a_s2[i]);
			end
			OP_NORM, OP_INV: begin
				for (int i = 0; i < 4; i++)
					sv[i].v = a_s2[i];
			end
			OP_NLERP: begin
				for (int i = 0; i < 4; i++)
					sv[i] = sat32(p[i] + p[i + 4]);
			end
			OP_MAT: begin
				em[0] = sat32((p[0] <<< 1) + (p[1] <<< 1) - ONE_64);
				em[1] = sat32((p[4] <<< 1) - (p[9] <<< 1));
				em[2] = sat32((p[5] <<< 1) + (p[8] <<< 1));
				em[3] = sat32((p[4] <<< 1) + (p[9] <<< 1));
				em[4] = sat32((p[0] <<< 1) + (p[2] <<< 1) - ONE_64);
				em[5] = sat32((p[6] <<< 1) - (p[7] <<< 1));
				em[6] = sat32((p[5] <<< 1) - (p[8] <<< 1));
				em[7] = sat32((p[6] <<< 1) + (p[7] <<< 1));
				em[8] = sat32((p[0] <<< 1) + (p[3] <<< 1) - ONE_64);
			end
			default: ;
		endcase
		if (mode_s2 == OP_MAT) begin
			for (int i = 0; i < 3; i++) begin
				c_nxt.res[i]      = em[i].v;
				c_nxt.mrow[i]     = em[3 + i].v;
				c_nxt.mrow[3 + i] = em[6 + i].v;
			end
			c_nxt.flag[0] = em[0].f | em[1].f | em[2].f;
			c_nxt.flag[1] = em[3].f | em[4].f | em[5].f;
			c_nxt.flag[2] = em[6].f | em[7].f | em[8].f;
		end else begin
			for (int i = 0; i < 4; i++)
				c_nxt.res[i] = sv[i].v;
			c_nxt.flag[0] = sv[0].f | sv[1].f | sv[2].f | sv[3].f;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			mag[i] = c_s3.res[i][31] ? 32'd0 - c_s3.res[i] : c_s3.res[i];
		c5_nxt    = c_s4;
		c5_nxt.sq = 65'(sq_s4[0]) + 65'(sq_s4[1]) + 65'(sq_s4[2]) + 65'(sq_s4[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s1   <= lx;
			ly_s1   <= ly;
			a_s1    <= a;
			b_s1    <= b;
			mode_s1 <= mode;
			for (int k = 0; k < 16; k++)
				p_s2[k] <= 64'(prod[k] >>> FRAC_BITS);
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			mode_s2 <= mode_s1;
			c_s3    <= c_nxt;
			for (int i = 0; i < 4; i++)
				sq_s4[i] <= mag[i] * mag[i];
			c_s4    <= c_s3;
			c_s5    <= c5_nxt;
		end
	end

	assign out_valid = v_s5;
	assign out_carry = c_s5;

endmodule

// ===== src/qau_sqrt.sv =====
// Pipelined integer square root of the 65-bit sum of squares, one root bit per stage.
module qau_sqrt import qau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  carry_t      in_carry,
	output logic        out_valid,
	output carry_t      out_carry,
	output logic [32:0] out_root
);

	localparam int NSTG = 33;

	logic [33:0] rem_s  [NSTG];
	logic [32:0] root_s [NSTG];
	carry_t      c_s    [NSTG];
	logic        v_s    [NSTG];

	logic [33:0] rem_n  [NSTG];
	logic [32:0] root_n [NSTG];
	carry_t      c_n    [NSTG];
	logic        v_n    [NSTG];

	always_comb begin
		logic [33:0] prem;
		logic [32:0] proot;
		logic [65:0] sq66;
		logic [35:0] tr;
		logic [35:0] trial;
		for (int k = 0; k < NSTG; k++) begin
			if (k == 0) begin
				prem   = '0;
				proot  = '0;
				c_n[k] = in_carry;
				v_n[k] = in_valid;
			end else begin
				prem   = rem_s[k - 1];
				proot  = root_s[k - 1];
				c_n[k] = c_s[k - 1];
				v_n[k] = v_s[k - 1];
			end
			sq66  = {1'b0, c_n[k].sq};
			tr    = {prem, sq66[2 * (NSTG - 1 - k) +: 2]};
			trial = {1'b0, proot, 2'b01};
			if (tr >= trial) begin
				rem_n[k]  = 34'(tr - trial);
				root_n[k] = {proot[31:0], 1'b1};
			end else begin
				rem_n[k]  = tr[33:0];
				root_n[k] = {proot[31:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTG; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s <= v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s  <= rem_n;
			root_s <= root_n;
			c_s    <= c_n;
		end
	end

	assign out_valid = v_s[NSTG - 1];
	assign out_carry = c_s[NSTG - 1];
	assign out_root  = root_s[NSTG - 1];

endmodule

// ===== src/qau_div.sv =====
// Four-lane pipelined restoring divider: |r|*2^FRAC_BITS / norm or norm^2, one bit per stage.
module qau_div import qau_pkg::*; #(
	parameter int FRAC_BITS = QAU_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  carry_t      in_carry,
	input  logic [32:0] in_root,
	output logic        out_valid,
	output carry_t      out_carry,
	output div_res_t    out_res
);

	localparam int XW   = 32 + FRAC_BITS;
	localparam int NSTG = 34;

	logic [64:0] rem_s [NSTG][4];
	logic [32:0] q_s   [NSTG][4];
	logic [32:0] lo_s  [NSTG][4];
	logic [3:0]  ovf_s [NSTG];
	logic [64:0] d_s   [NSTG];
	logic        z_s   [NSTG];
	carry_t      c_s   [NSTG];
	logic        v_s   [NSTG];

	logic [64:0] rem_n [NSTG][4];
	logic [32:0] q_n   [NSTG][4];
	logic [32:0] lo_n  [NSTG][4];
	logic [3:0]  ovf_n [NSTG];
	logic [64:0] d_n   [NSTG];
	logic        z_n   [NSTG];
	carry_t      c_n   [NSTG];
	logic        v_n   [NSTG];

	always_comb begin
		logic [64:0] dsel;
		logic [31:0] mg;
		logic [XW-1:0] x;
		logic [64:0] r0;
		logic [65:0] tr;
		logic        ge;
		// Entry stage: pick divisor (norm^2 for OP_INV), split dividend, check for quotient at or past 2^33.
		dsel = (in_carry.mode == OP_INV) ? (in_carry.sq >> FRAC_BITS) : {32'd0, in_root};
		d_n[0] = dsel;
		z_n[0] = (dsel == '0);
		c_n[0] = in_carry;
		v_n[0] = in_valid;
		for (int i = 0; i < 4; i++) begin
			mg = in_carry.res[i][31] ? 32'd0 - in_carry.res[i] : in_carry.res[i];
			x  = {mg, {FRAC_BITS{1'b0}}};
			r0 = 65'(x >> 33);
			rem_n[0][i]  = r0;
			q_n[0][i]    = '0;
			lo_n[0][i]   = x[32:0];
			ovf_n[0][i]  = (r0 >= dsel);
		end
		for (int k = 1; k < NSTG; k++) begin
			d_n[k]   = d_s[k - 1];
			z_n[k]   = z_s[k - 1];
			c_n[k]   = c_s[k - 1];
			v_n[k]   = v_s[k - 1];
			ovf_n[k] = ovf_s[k - 1];
			for (int i = 0; i < 4; i++) begin
				tr = {rem_s[k - 1][i], lo_s[k - 1][i][32]};
				ge = (tr >= {1'b0, d_s[k - 1]});
				rem_n[k][i] = ge ? 65'(tr - {1'b0, d_s[k - 1]}) : tr[64:0];
				q_n[k][i]   = {q_s[k - 1][i][31:0], ge};
				lo_n[k][i]  = {lo_s[k - 1][i][31:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTG; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s <= v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_n;
			q_s   <= q_n;
			lo_s  <= lo_n;
			ovf_s <= ovf_n;
			d_s   <= d_n;
			z_s   <= z_n;
			c_s   <= c_n;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			out_res.q[i] = q_s[NSTG - 1][i];
		out_res.ovf  = ovf_s[NSTG - 1];
		out_res.zero = z_s[NSTG - 1];
	end

	assign out_valid = v_s[NSTG - 1];
	assign out_carry = c_s[NSTG - 1];

endmodule

// ===== src/qau_out.sv =====
// Result assembly and output register; a matrix item leaves as three row beats.
module qau_out import qau_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  carry_t       in_carry,
	input  div_res_t     in_res,
	output logic         en,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,
	output logic [3:0]   m_tuser,
	output logic         m_tlast
);

	logic [2:0][2:0][31:0] rv;
	logic [31:0]           rz;
	logic [2:0][1:0]       st;
	logic                  mat;

	logic [2:0][2:0][31:0] rv_q;
	logic [31:0]           rz_q;
	logic [2:0][1:0]       st_q;
	logic                  mat_q;
	logic                  valid_q;
	logic [1:0]            row_q;
	logic                  last;

	always_comb begin
		sat_t ds;
		sat_t ns;
		logic f;
		logic [3:0][31:0] qv;
		rv  = '0;
		rz  = '0;
		st  = '0;
		mat = 1'b0;
		f   = 1'b0;
		qv  = '0;
		ds  = '0;
		ns  = '0;
		case (in_carry.mode)
			OP_MAT: begin
				mat = 1'b1;
				for (int i = 0; i < 3; i++) begin
					rv[0][i] = in_carry.res[i];
					rv[1][i] = in_carry.mrow[i];
					rv[2][i] = in_carry.mrow[3 + i];
				end
				for (int k = 0; k < 3; k++)
					st[k] = in_carry.flag[k] ? ST_SAT : ST_OK;
			end
			OP_NORM, OP_INV, OP_NLERP: begin
				if (in_res.zero) begin
					st[0] = ST_ZERO;
				end else begin
					f = in_carry.flag[0];
					for (int i = 0; i < 4; i++) begin
						ds = div_sat(in_carry.res[i][31], in_res.q[i], in_res.ovf[i]);
						f  = f | ds.f;
						if (in_carry.mode == OP_INV && i > 0) begin
							ns    = neg_sat(ds.v);
							f     = f | ns.f;
							qv[i] = ns.v;
						end else begin
							qv[i] = ds.v;
						end
					end
					for (int i = 0; i < 3; i++)
						rv[0][i] = qv[i];
					rz    = qv[3];
					st[0] = f ? ST_SAT : ST_OK;
				end
			end
			default: begin
				for (int i = 0; i < 3; i++)
					rv[0][i] = in_carry.res[i];
				rz    = in_carry.res[3];
				st[0] = in_carry.flag[0] ? ST_SAT : ST_OK;
			end
		endcase
	end

	assign last = !mat_q || (row_q == 2'd2);
	// Advance the pipeline only when the held item has left or is leaving on this beat.
	assign en   = !valid_q || (m_tready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			row_q   <= '0;
		end else if (en) begin
			valid_q <= in_valid;
			row_q   <= '0;
		end else if (m_tready) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			rv_q  <= rv;
			rz_q  <= rz;
			st_q  <= st;
			mat_q <= mat;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {rz_q, rv_q[row_q][2], rv_q[row_q][1], rv_q[row_q][0]};
	assign m_tuser  = {st_q[row_q], row_q};
	assign m_tlast  = last;

endmodule

// ===== src/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit top level: stream ports and pipeline assembly.
// Fixed-point quaternion unit (Q16.16 by default). Every op runs down one 73-stage pipeline:
// 5 front stages (operand routing, product lanes, combine, sum of squares), a 33-stage square
// root, a 34-stage four-lane divider and the output register. One item is taken per cycle; a
// to_matrix item holds the pipeline for its three row beats. Backpressure on the result side
// stalls every stage at once.
module quaternion_arithmetic_unit import qau_pkg::*; #(
	parameter int FRAC_BITS = QAU_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor
	input  logic [3:0]   s_tuser,   // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // r_w, r_x, r_y, r_z
	output logic [3:0]   m_tuser,   // row, status
	output logic         m_tlast
);

	logic     en;
	logic     f_valid;
	carry_t   f_carry;
	logic     r_valid;
	carry_t   r_carry;
	logic [32:0] r_root;
	logic     d_valid;
	carry_t   d_carry;
	div_res_t d_res;

	assign s_tready = en;

	qau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.mode      (s_tuser),
		.a         (s_tdata[127:0]),
		.b         (s_tdata[255:128]),
		.factor    (s_tdata[287:256]),
		.out_valid (f_valid),
		.out_carry (f_carry)
	);

	qau_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_carry  (f_carry),
		.out_valid (r_valid),
		.out_carry (r_carry),
		.out_root  (r_root)
	);

	qau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.in_carry  (r_carry),
		.in_root   (r_root),
		.out_valid (d_valid),
		.out_carry (d_carry),
		.out_res   (d_res)
	);

	qau_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.in_carry (d_carry),
		.in_res   (d_res),
		.en       (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
